// ----- design/cupdisp_pkg.sv -----
package cupdisp_pkg;

	// Default channel count and the number of channels wired to the sensor and command fields
	localparam int CHANNELS_DEF = 3;
	localparam int IO_LANES     = 3;

	// Field widths
	localparam int MASK_W  = 3;
	localparam int CMD_W   = 2;
	localparam int PHASE_W = 3;
	localparam int REG_W   = 8;
	localparam int IDX_W   = 3;
	localparam int SCAN_W  = 16;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_WAIT_TIMEOUT = 3'd0;
	localparam logic [IDX_W-1:0] REG_DRY_CONFIRM  = 3'd1;
	localparam logic [IDX_W-1:0] REG_CUP_IN       = 3'd2;
	localparam logic [IDX_W-1:0] REG_CUP_OUT      = 3'd3;
	localparam logic [IDX_W-1:0] REG_POST_DRAW    = 3'd4;

	// Register reset values
	localparam logic [REG_W-1:0] WAIT_TIMEOUT_RST = 8'd22;
	localparam logic [REG_W-1:0] DRY_CONFIRM_RST  = 8'd28;
	localparam logic [REG_W-1:0] CUP_IN_RST       = 8'd3;
	localparam logic [REG_W-1:0] CUP_OUT_RST      = 8'd5;
	localparam logic [REG_W-1:0] POST_DRAW_RST    = 8'd6;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE  = 3'd0,
		PH_WAIT  = 3'd1,
		PH_RUN   = 3'd2,
		PH_END   = 3'd3,
		PH_DRAIN = 3'd4
	} phase_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_KEEP    = 2'd0,
		CMD_ENABLE  = 2'd1,
		CMD_DISABLE = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [REG_W-1:0] wait_timeout;
		logic [REG_W-1:0] dry_confirm;
		logic [REG_W-1:0] cup_in;
		logic [REG_W-1:0] cup_out;
		logic [REG_W-1:0] post_draw;
	} cfg_t;

	typedef struct packed {
		logic   pump;
		logic   red;
		logic   green;
		logic   water_ok;
		logic   drain;
		phase_t phase;
	} chan_res_t;

	// Saturating increment of a debounce counter
	function automatic logic [REG_W-1:0] sat_inc8(input logic [REG_W-1:0] v);
		return (v == {REG_W{1'b1}}) ? v : v + 8'd1;
	endfunction

endpackage

// ----- design/cupdisp_if.sv -----
interface cupdisp_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] cup_sense;
	logic [2:0] water_sense;
	logic [1:0] cmd_first;
	logic [1:0] cmd_second;
	logic [1:0] cmd_third;

	modport source (output valid, cup_sense, water_sense, cmd_first, cmd_second, cmd_third,
		input ready);
	modport sink (input valid, cup_sense, water_sense, cmd_first, cmd_second, cmd_third,
		output ready);
endinterface

interface cupdisp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] pump_mask;
	logic [2:0] red_led_mask;
	logic [2:0] green_led_mask;
	logic [2:0] water_ok_mask;
	logic [2:0] drain_pulse_mask;
	logic [2:0] phase_first;
	logic [2:0] phase_second;
	logic [2:0] phase_third;

	modport source (output valid, pump_mask, red_led_mask, green_led_mask, water_ok_mask,
		drain_pulse_mask, phase_first, phase_second, phase_third, input ready);
	modport sink (input valid, pump_mask, red_led_mask, green_led_mask, water_ok_mask,
		drain_pulse_mask, phase_first, phase_second, phase_third, output ready);
endinterface

// ----- design/cup_dispense_channel_fsm.sv -----
// Each result is registered: it appears in the output register the cycle after its input transaction.
// Throughput: one scan tick per cycle; the input is taken whenever the output register
//   is empty or being drained in the same cycle.
// Each tick runs every channel's phase machine once in combinational logic between
//   the channel state registers and the output register.
// Reset (arst_n low, asynchronous): channels in waiting with water_ok set, counters and
//   pump and LED state cleared, registers at their default values, no result pending.
module cup_dispense_channel_fsm #(
	parameter int CHANNELS = cupdisp_pkg::CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cupdisp_pkg::IDX_W-1:0]  cfg_idx,
	input  logic [cupdisp_pkg::REG_W-1:0]  cfg_wdata,
	cupdisp_in_if.sink                     in_ch,
	cupdisp_out_if.source                  out_ch
);
	import cupdisp_pkg::*;

	cfg_t                cfg_q;
	logic                adv;
	logic                out_valid_q;
	logic [CMD_W-1:0]    cmd_lane [IO_LANES];
	chan_res_t           res      [CHANNELS];
	chan_res_t           lane_res [IO_LANES];
	chan_res_t           res_q    [IO_LANES];

	assign adv         = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !out_valid_q || out_ch.ready;

	assign cmd_lane[0] = in_ch.cmd_first;
	assign cmd_lane[1] = in_ch.cmd_second;
	assign cmd_lane[2] = in_ch.cmd_third;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_timeout <= WAIT_TIMEOUT_RST;
			cfg_q.dry_confirm  <= DRY_CONFIRM_RST;
			cfg_q.cup_in       <= CUP_IN_RST;
			cfg_q.cup_out      <= CUP_OUT_RST;
			cfg_q.post_draw    <= POST_DRAW_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WAIT_TIMEOUT: cfg_q.wait_timeout <= cfg_wdata;
				REG_DRY_CONFIRM:  cfg_q.dry_confirm  <= cfg_wdata;
				REG_CUP_IN:       cfg_q.cup_in       <= cfg_wdata;
				REG_CUP_OUT:      cfg_q.cup_out      <= cfg_wdata;
				REG_POST_DRAW:    cfg_q.post_draw    <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	// One phase machine per channel; channels past the sensor lanes see nothing
	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		if (c < IO_LANES) begin : g_io
			cupdisp_chan u_chan (
				.clk    (clk),
				.arst_n (arst_n),
				.cfg    (cfg_q),
				.adv    (adv),
				.cup    (in_ch.cup_sense[c]),
				.wet    (in_ch.water_sense[c]),
				.cmd    (cmd_lane[c]),
				.res    (res[c])
			);
		end else begin : g_dark
			cupdisp_chan u_chan (
				.clk    (clk),
				.arst_n (arst_n),
				.cfg    (cfg_q),
				.adv    (adv),
				.cup    (1'b0),
				.wet    (1'b0),
				.cmd    (CMD_KEEP),
				.res    (res[c])
			);
		end
	end

	// Pick the channels that appear in the outputs; absent ones read as idle and dark
	for (genvar l = 0; l < IO_LANES; l++) begin : g_lane
		if (l < CHANNELS) begin : g_on
			assign lane_res[l] = res[l];
		end else begin : g_off
			assign lane_res[l] = '{pump: 1'b0, red: 1'b0, green: 1'b0, water_ok: 1'b0,
				drain: 1'b0, phase: PH_IDLE};
		end
	end

	// Output register: load on accept, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= lane_res;
	end

	assign out_ch.valid = out_valid_q;
	for (genvar l = 0; l < IO_LANES; l++) begin : g_out
		assign out_ch.pump_mask[l]        = res_q[l].pump;
		assign out_ch.red_led_mask[l]     = res_q[l].red;
		assign out_ch.green_led_mask[l]   = res_q[l].green;
		assign out_ch.water_ok_mask[l]    = res_q[l].water_ok;
		assign out_ch.drain_pulse_mask[l] = res_q[l].drain;
	end
	assign out_ch.phase_first  = res_q[0].phase;
	assign out_ch.phase_second = res_q[1].phase;
	assign out_ch.phase_third  = res_q[2].phase;

endmodule

// ----- design/cupdisp_chan.sv -----
module cupdisp_chan (
	input  logic                clk,
	input  logic                arst_n,
	input  cupdisp_pkg::cfg_t   cfg,
	input  logic                adv,
	input  logic                cup,
	input  logic                wet,
	input  logic [1:0]          cmd,
	output cupdisp_pkg::chan_res_t res
);
	import cupdisp_pkg::*;

	phase_t            phase_q, ph;
	logic [SCAN_W-1:0] scan_q, sc;
	logic [REG_W-1:0]  dry_q, dry;
	logic [REG_W-1:0]  cin_q, cin;
	logic [REG_W-1:0]  cout_q, cout;
	logic              tflag_q, tflag;
	logic              wok_q, wok;
	logic              act_q, act;
	logic              red_q, red;
	logic              grn_q, grn;
	logic              drain;
	logic              placed;
	logic              removed_run;
	logic              removed_end;

	// Hold state between ticks, advance on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			scan_q  <= '0;
			dry_q   <= '0;
			cin_q   <= '0;
			cout_q  <= '0;
			tflag_q <= 1'b0;
			wok_q   <= 1'b1;
			act_q   <= 1'b0;
			red_q   <= 1'b0;
			grn_q   <= 1'b0;
		end else if (adv) begin
			phase_q <= ph;
			scan_q  <= sc;
			dry_q   <= dry;
			cin_q   <= cin;
			cout_q  <= cout;
			tflag_q <= tflag;
			wok_q   <= wok;
			act_q   <= act;
			red_q   <= red;
			grn_q   <= grn;
		end
	end

	// Next state: phases evaluated in order so a transition cascades within one tick
	always_comb begin
		ph          = phase_q;
		sc          = scan_q;
		dry         = dry_q;
		cin         = cin_q;
		cout        = cout_q;
		tflag       = tflag_q;
		wok         = wok_q;
		act         = act_q;
		red         = red_q;
		grn         = grn_q;
		drain       = 1'b0;
		placed      = 1'b0;
		removed_run = 1'b0;
		removed_end = 1'b0;

		if (sc != {SCAN_W{1'b1}})
			sc = sc + 16'd1;

		case (cmd)
			CMD_ENABLE:  ph = PH_WAIT;
			CMD_DISABLE: ph = PH_IDLE;
			default:     ;
		endcase

		// Waiting: green on, debounce cup placement
		if (ph == PH_WAIT) begin
			grn = 1'b1;
			if (cup) begin
				cin = sat_inc8(cin);
				if (cin >= cfg.cup_in) begin
					cin    = '0;
					placed = 1'b1;
				end
			end
			if (placed) begin
				ph    = PH_RUN;
				grn   = 1'b0;
				sc    = '0;
				tflag = 1'b0;
			end
		end

		// Running: pump on, watch for dry water after timeout or cup removal
		if (ph == PH_RUN) begin
			red = 1'b1;
			act = 1'b1;
			if (sc >= {8'd0, cfg.wait_timeout} && !tflag) begin
				sc    = '0;
				tflag = 1'b1;
			end
			if (!wet) begin
				dry = sat_inc8(dry);
				if (dry >= cfg.dry_confirm) begin
					wok = 1'b0;
					dry = '0;
				end
			end else begin
				wok = 1'b1;
				dry = '0;
			end
			// Removal detector is skipped when the dry stop already holds
			if (!(!wok && tflag) && !cup) begin
				cout = sat_inc8(cout);
				if (cout >= cfg.cup_out) begin
					cout        = '0;
					removed_run = 1'b1;
				end
			end
			if ((!wok && tflag) || removed_run) begin
				tflag = 1'b1;
				ph    = PH_END;
				red   = 1'b0;
				act   = 1'b0;
				drain = 1'b1;
			end else begin
				tflag = 1'b0;
			end
		end

		// Ending: blink both LEDs until the cup is gone
		if (ph == PH_END) begin
			tflag = 1'b0;
			grn   = ~grn;
			red   = ~red;
			if (!cup) begin
				cout = sat_inc8(cout);
				if (cout >= cfg.cup_out) begin
					cout        = '0;
					removed_end = 1'b1;
				end
			end
			if (removed_end) begin
				ph  = PH_DRAIN;
				red = 1'b0;
				grn = 1'b0;
				sc  = '0;
			end
		end

		// Draining: pump on with red blinking for the post-draw window
		if (ph == PH_DRAIN) begin
			if (sc <= {8'd0, cfg.post_draw}) begin
				red = ~red;
				act = 1'b1;
			end else begin
				red = 1'b0;
				grn = 1'b0;
				act = 1'b0;
				ph  = PH_WAIT;
				sc  = '0;
			end
		end
	end

	assign res.pump     = act;
	assign res.red      = red;
	assign res.green    = grn;
	assign res.water_ok = wok;
	assign res.drain    = drain;
	assign res.phase    = ph;

endmodule

// ----- design/cupdisp_chk.sv -----
module cupdisp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] drain_mask,
	input logic [2:0] pump_mask,
	input logic [2:0] phase_first
);
	import cupdisp_pkg::*;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drain_mask) && $stable(pump_mask))
		else $error("stalled result changed");

	// Every accepted transaction gives a result the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("result missing after accepted transaction");

	// Empty output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// A drain pulse leaves the first channel ending or draining
	a_drain_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drain_mask[0] |->
			(phase_first == PH_END) || (phase_first == PH_DRAIN))
		else $error("drain pulse outside ending or draining");

endmodule

bind cup_dispense_channel_fsm cupdisp_chk u_cupdisp_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.drain_mask  (out_ch.drain_pulse_mask),
	.pump_mask   (out_ch.pump_mask),
	.phase_first (out_ch.phase_first)
);

// ----- tb/sv/cup_dispense_channel_fsm_tb.sv -----
module cup_dispense_channel_fsm_tb;
	import cupdisp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_OFF_CYCLES = 48;

	typedef struct packed {
		logic [2:0]       cups;
		logic [2:0]       waters;
		logic [CMD_W-1:0] cmd_first;
		logic [CMD_W-1:0] cmd_second;
		logic [CMD_W-1:0] cmd_third;
	} scan_tick_t;

	typedef struct packed {
		logic [2:0] pump, red, green, water_ok, drain;
		logic [2:0] phase_first, phase_second, phase_third;
	} dispense_out_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_idx;
	logic [REG_W-1:0]    cfg_wdata;

	cupdisp_in_if  in_bus ();
	cupdisp_out_if out_bus ();

	cup_dispense_channel_fsm uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_bus),
		.out_ch   (out_bus)
	);

	// Shadow copy of the register file and of every channel's machine
	cfg_t             cfg_now;
	phase_t           ch_phase [3];
	logic [SCAN_W-1:0] ch_scan [3];
	logic [REG_W-1:0] ch_dry [3];
	logic [REG_W-1:0] ch_cup_in [3];
	logic [REG_W-1:0] ch_cup_out [3];
	logic             ch_timeout [3];
	logic             ch_water_ok [3];
	logic             ch_pump [3];
	logic             ch_red [3];
	logic             ch_green [3];

	scan_tick_t    pending_ticks [$];
	dispense_out_t expected_outputs [$];
	scan_tick_t    offered;

	int unsigned queued_total = 0;
	int unsigned sent_total = 0;
	int unsigned got_total = 0;
	int unsigned fail_count = 0;
	int unsigned pulse_total = 0;
	int unsigned cycle_count = 0;
	int unsigned settings_run = 0;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	int unsigned recv_hold = 0;
	logic [7:0]  phases_seen = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Debounce cup removal; the counter is shared by running and ending
	function automatic logic removal_seen(input int c, input logic cup);
		if (cup)
			return 1'b0;
		if (ch_cup_out[c] != '1)
			ch_cup_out[c] = ch_cup_out[c] + 8'd1;
		if (ch_cup_out[c] >= cfg_now.cup_out) begin
			ch_cup_out[c] = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance all channels by one scan tick and return the output masks
	function automatic dispense_out_t dispense_tick(input scan_tick_t tk);
		dispense_out_t    res;
		logic [CMD_W-1:0] cmd;
		logic             cup;
		logic             wet;
		logic             stop;
		res = '0;
		for (int c = 0; c < 3; c++) begin
			cup = tk.cups[c];
			wet = tk.waters[c];
			case (c)
				0: cmd = tk.cmd_first;
				1: cmd = tk.cmd_second;
				default: cmd = tk.cmd_third;
			endcase

			if (ch_scan[c] != '1)
				ch_scan[c] = ch_scan[c] + 16'd1;
			if (cmd == CMD_ENABLE)
				ch_phase[c] = PH_WAIT;
			else if (cmd == CMD_DISABLE)
				ch_phase[c] = PH_IDLE;

			// Waiting: light green, debounce a placed cup
			if (ch_phase[c] == PH_WAIT) begin
				ch_green[c] = 1'b1;
				if (cup) begin
					if (ch_cup_in[c] != '1)
						ch_cup_in[c] = ch_cup_in[c] + 8'd1;
					if (ch_cup_in[c] >= cfg_now.cup_in) begin
						ch_cup_in[c] = '0;
						ch_phase[c] = PH_RUN;
						ch_green[c] = 1'b0;
						ch_scan[c] = '0;
						ch_timeout[c] = 1'b0;
					end
				end
			end

			// Running: pump on, watch for dry water past the timeout or cup removal
			if (ch_phase[c] == PH_RUN) begin
				ch_red[c] = 1'b1;
				ch_pump[c] = 1'b1;
				if (ch_scan[c] >= SCAN_W'(cfg_now.wait_timeout) && !ch_timeout[c]) begin
					ch_scan[c] = '0;
					ch_timeout[c] = 1'b1;
				end
				if (!wet) begin
					if (ch_dry[c] != '1)
						ch_dry[c] = ch_dry[c] + 8'd1;
					if (ch_dry[c] >= cfg_now.dry_confirm) begin
						ch_water_ok[c] = 1'b0;
						ch_dry[c] = '0;
					end
				end else begin
					ch_water_ok[c] = 1'b1;
					ch_dry[c] = '0;
				end
				// A confirmed dry stop skips the removal debounce this tick
				stop = !ch_water_ok[c] && ch_timeout[c];
				if (!stop)
					stop = removal_seen(c, cup);
				if (stop) begin
					ch_timeout[c] = 1'b1;
					ch_phase[c] = PH_END;
					ch_red[c] = 1'b0;
					ch_pump[c] = 1'b0;
					res.drain[c] = 1'b1;
				end else begin
					ch_timeout[c] = 1'b0;
				end
			end

			// Ending: blink both LEDs until the cup is gone
			if (ch_phase[c] == PH_END) begin
				ch_timeout[c] = 1'b0;
				ch_green[c] = ~ch_green[c];
				ch_red[c] = ~ch_red[c];
				if (removal_seen(c, cup)) begin
					ch_phase[c] = PH_DRAIN;
					ch_red[c] = 1'b0;
					ch_green[c] = 1'b0;
					ch_scan[c] = '0;
				end
			end

			// Draining: keep drawing for the post-removal window
			if (ch_phase[c] == PH_DRAIN) begin
				if (ch_scan[c] <= SCAN_W'(cfg_now.post_draw)) begin
					ch_red[c] = ~ch_red[c];
					ch_pump[c] = 1'b1;
				end else begin
					ch_red[c] = 1'b0;
					ch_green[c] = 1'b0;
					ch_pump[c] = 1'b0;
					ch_phase[c] = PH_WAIT;
					ch_scan[c] = '0;
				end
			end

			res.pump[c] = ch_pump[c];
			res.red[c] = ch_red[c];
			res.green[c] = ch_green[c];
			res.water_ok[c] = ch_water_ok[c];
		end
		res.phase_first = ch_phase[0];
		res.phase_second = ch_phase[1];
		res.phase_third = ch_phase[2];
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [2:0] want,
		input logic [2:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic queue_tick(input logic [2:0] cups, input logic [2:0] waters,
		input logic [CMD_W-1:0] c0, input logic [CMD_W-1:0] c1, input logic [CMD_W-1:0] c2);
		scan_tick_t tk;
		tk.cups = cups;
		tk.waters = waters;
		tk.cmd_first = c0;
		tk.cmd_second = c1;
		tk.cmd_third = c2;
		pending_ticks.push_back(tk);
		queued_total++;
	endtask

	// Cups come and go in stretches long enough to pass the debounce, with short
	// glitches mixed in; water is mostly present with dry spells; commands are rare
	task automatic queue_random(input int n, input int cup_span, input int wet_span);
		logic [2:0]       cups;
		logic [2:0]       wets;
		int               cup_left [3];
		int               wet_left [3];
		logic [CMD_W-1:0] cmds [3];
		int unsigned      odds;
		int unsigned      r;
		cups = '0;
		wets = '1;
		odds = 8 * cup_span + 40;
		for (int c = 0; c < 3; c++) begin
			cup_left[c] = $urandom_range(0, 3);
			wet_left[c] = $urandom_range(wet_span, 3 * wet_span);
		end
		repeat (n) begin
			for (int c = 0; c < 3; c++) begin
				if (cup_left[c] == 0) begin
					cups[c] = ~cups[c];
					cup_left[c] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) :
						$urandom_range(cup_span, 2 * cup_span);
				end
				cup_left[c]--;
				if (wet_left[c] == 0) begin
					wets[c] = ~wets[c];
					if (wets[c])
						wet_left[c] = $urandom_range(wet_span, 4 * wet_span);
					else
						wet_left[c] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) :
							$urandom_range(wet_span, 2 * wet_span);
				end
				wet_left[c]--;
				r = $urandom_range(0, odds - 1);
				case (r)
					0: cmds[c] = CMD_DISABLE;
					1, 2: cmds[c] = CMD_ENABLE;
					3: cmds[c] = CMD_RESERVED;
					default: cmds[c] = CMD_KEEP;
				endcase
			end
			queue_tick(cups, wets, cmds[0], cmds[1], cmds[2]);
		end
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WAIT_TIMEOUT: cfg_now.wait_timeout = val;
			REG_DRY_CONFIRM: cfg_now.dry_confirm = val;
			REG_CUP_IN: cfg_now.cup_in = val;
			REG_CUP_OUT: cfg_now.cup_out = val;
			REG_POST_DRAW: cfg_now.post_draw = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [REG_W-1:0] wt, input logic [REG_W-1:0] dc,
		input logic [REG_W-1:0] ci, input logic [REG_W-1:0] co, input logic [REG_W-1:0] pd);
		write_reg(REG_WAIT_TIMEOUT, wt);
		write_reg(REG_DRY_CONFIRM, dc);
		write_reg(REG_CUP_IN, ci);
		write_reg(REG_CUP_OUT, co);
		write_reg(REG_POST_DRAW, pd);
		settings_run++;
	endtask

	// Hold until every queued tick is taken and every result has come back
	task automatic wait_quiet();
		while (sent_total != queued_total || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: offer queued ticks, predict each accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_bus.valid && in_bus.ready) begin
				expected_outputs.push_back(dispense_tick(offered));
				sent_total++;
				send_gap = (((sent_total / 160) % 4) == 3) ? 0 : $urandom_range(0, 8);
			end
			if (!in_bus.valid || in_bus.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_bus.valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					offered = pending_ticks.pop_front();
					in_bus.valid <= 1'b1;
					in_bus.cup_sense <= offered.cups;
					in_bus.water_sense <= offered.waters;
					in_bus.cmd_first <= offered.cmd_first;
					in_bus.cmd_second <= offered.cmd_second;
					in_bus.cmd_third <= offered.cmd_third;
				end else begin
					in_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: compare each result transaction, then stall or hold off
	always @(posedge clk) begin
		dispense_out_t want;
		if (arst_n) begin
			if (out_bus.valid && out_bus.ready) begin
				got_total++;
				if (expected_outputs.size() == 0) begin
					$error("result transaction with no scan tick pending");
					fail_count++;
				end else begin
					want = expected_outputs.pop_front();
					check_field("pump_mask", want.pump, out_bus.pump_mask);
					check_field("red_led_mask", want.red, out_bus.red_led_mask);
					check_field("green_led_mask", want.green, out_bus.green_led_mask);
					check_field("water_ok_mask", want.water_ok, out_bus.water_ok_mask);
					check_field("drain_pulse_mask", want.drain, out_bus.drain_pulse_mask);
					check_field("phase_first", want.phase_first, out_bus.phase_first);
					check_field("phase_second", want.phase_second, out_bus.phase_second);
					check_field("phase_third", want.phase_third, out_bus.phase_third);
				end
				if (out_bus.drain_pulse_mask != '0)
					pulse_total++;
				phases_seen[out_bus.phase_first] = 1'b1;
				phases_seen[out_bus.phase_second] = 1'b1;
				phases_seen[out_bus.phase_third] = 1'b1;
				recv_stall = (((got_total / 200) % 4) == 1) ? 0 : $urandom_range(0, 8);
				if (got_total == 500 || got_total == 1150)
					recv_hold = HOLD_OFF_CYCLES;
			end
			if (recv_hold != 0) begin
				recv_hold--;
				out_bus.ready <= 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall--;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= 1'b1;
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_bus.valid = 1'b0;
		in_bus.cup_sense = '0;
		in_bus.water_sense = '0;
		in_bus.cmd_first = CMD_KEEP;
		in_bus.cmd_second = CMD_KEEP;
		in_bus.cmd_third = CMD_KEEP;
		out_bus.ready = 1'b0;

		cfg_now.wait_timeout = WAIT_TIMEOUT_RST;
		cfg_now.dry_confirm = DRY_CONFIRM_RST;
		cfg_now.cup_in = CUP_IN_RST;
		cfg_now.cup_out = CUP_OUT_RST;
		cfg_now.post_draw = POST_DRAW_RST;
		for (int c = 0; c < 3; c++) begin
			ch_phase[c] = PH_WAIT;
			ch_scan[c] = '0;
			ch_dry[c] = '0;
			ch_cup_in[c] = '0;
			ch_cup_out[c] = '0;
			ch_timeout[c] = 1'b0;
			ch_water_ok[c] = 1'b1;
			ch_pump[c] = 1'b0;
			ch_red[c] = 1'b0;
			ch_green[c] = 1'b0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: place cups everywhere, try every command, remove, drain
		repeat (3) queue_tick(3'b111, 3'b111, CMD_KEEP, CMD_KEEP, CMD_KEEP);
		queue_tick(3'b111, 3'b000, CMD_RESERVED, CMD_RESERVED, CMD_RESERVED);
		// disable while running leaves the pump on
		queue_tick(3'b111, 3'b111, CMD_DISABLE, CMD_KEEP, CMD_KEEP);
		queue_tick(3'b000, 3'b111, CMD_ENABLE, CMD_KEEP, CMD_KEEP);
		repeat (10) queue_tick(3'b000, 3'b111, CMD_KEEP, CMD_KEEP, CMD_KEEP);
		repeat (8) queue_tick(3'b000, 3'b000, CMD_KEEP, CMD_KEEP, CMD_KEEP);
		queue_tick(3'b111, 3'b111, CMD_DISABLE, CMD_DISABLE, CMD_DISABLE);
		queue_tick(3'b000, 3'b111, CMD_ENABLE, CMD_ENABLE, CMD_ENABLE);

		// Random at reset settings
		queue_random(200, 6, 30);
		wait_quiet();

		// Thresholds of one and a zero post-draw setting: dry stop right at the timeout
		load_settings(8'd1, 8'd1, 8'd1, 8'd1, 8'd0);
		queue_random(200, 2, 3);
		wait_quiet();

		// Largest thresholds
		load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		queue_random(600, 260, 260);
		wait_quiet();

		// Zero thresholds fire on the first sample
		load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		queue_random(100, 2, 2);
		wait_quiet();

		// Random mid-range settings
		load_settings(REG_W'($urandom_range(1, 40)), REG_W'($urandom_range(1, 40)),
			REG_W'($urandom_range(1, 10)), REG_W'($urandom_range(1, 10)),
			REG_W'($urandom_range(0, 20)));
		queue_random(200, 12, 20);
		wait_quiet();

		$display("checked %0d scan ticks across %0d register settings plus reset values",
			got_total, settings_run);
		$display("results with a drain pulse: %0d, phase codes seen: %b",
			pulse_total, phases_seen);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
design/cupdisp_pkg.sv
design/cupdisp_if.sv
design/cupdisp_chan.sv
design/cup_dispense_channel_fsm.sv
design/cupdisp_chk.sv
tb/sv/cup_dispense_channel_fsm_tb.sv
